[rtl/core/mcsp_pkg.sv]
// shared types and constants of the multi-channel soft pwm
package mcsp_pkg;

  localparam int unsigned MaxChannelsDef = 16;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned PinW           = 7;
  localparam int unsigned DutyW          = 8;
  localparam logic [7:0]  PhaseLast      = 8'd254;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SET  = 2'd1,
    KIND_STOP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_WRITE   = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [PinW-1:0]   pin;
    logic [DutyW-1:0]  duty;
    logic              inv;
  } cmd_t;

  typedef struct packed {
    logic [PinW-1:0] pin;
    logic            level;
    status_e         status;
    logic            last;
  } res_t;

endpackage

[rtl/core/mcsp_front.sv]
// command intake: decode, drop unused kinds, queue for the channel engine
module mcsp_front import mcsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       kind_i,
  input  logic [PinW-1:0]  pin_id_i,
  input  logic [DutyW-1:0] duty_i,
  input  logic             invert_i,
  output logic             busy_o,
  output cmd_t             cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i
);

  localparam int unsigned PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  cmd_t             q_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             kind_ok;
  logic             push;
  logic             pop;
  cmd_t             cmd_in;

  assign kind_ok = (kind_i == KIND_TICK) || (kind_i == KIND_SET) || (kind_i == KIND_STOP);
  assign busy_o  = (fill_q == FillW'(QueueDepth));
  assign push    = start_i && !busy_o && kind_ok;
  assign cmd_valid_o = (fill_q != '0);
  assign pop     = cmd_valid_o && cmd_ready_i;
  assign cmd_o   = q_q[rd_ptr_q];

  always_comb begin
    cmd_in      = '0;
    cmd_in.kind = kind_e'(kind_i);
    cmd_in.pin  = pin_id_i;
    cmd_in.duty = duty_i;
    cmd_in.inv  = invert_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[rtl/core/mcsp_back.sv]
// channel engine: channel table memory, tick walk, search, append and removal
module mcsp_back import mcsp_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CntW = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  typedef struct packed {
    logic [PinW-1:0]  pin;
    logic [DutyW-1:0] duty;
    logic             inv;
    logic             latch;
  } entry_t;

  entry_t          mem_q [MAX_CHANNELS];
  entry_t          rdata_q;

  state_e          state_q;
  cmd_t            cmd_q;
  logic [CntW-1:0] count_q;
  logic [7:0]      phase_q;
  logic [CntW-1:0] rd_idx_q;
  logic            pv_q;
  logic [IdxW-1:0] pidx_q;
  logic            held_v_q;
  logic [PinW-1:0] held_pin_q;
  logic            held_lvl_q;
  logic            stop_inv_q;
  logic            res_v_q;
  res_t            res_q;

  logic            rd_go;
  logic [IdxW-1:0] raddr;
  logic            scan_ev;
  logic            scan_done;
  logic            shift_ev;
  logic            shift_done;
  logic            hit;
  logic            ph0;
  logic            off_now;
  logic            emit_new;
  logic            new_lvl;
  logic            full;
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;

  assign rd_go      = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rd_idx_q < count_q);
  assign raddr      = rd_idx_q[IdxW-1:0];
  assign scan_ev    = (state_q == S_SCAN) && pv_q;
  assign scan_done  = (state_q == S_SCAN) && !pv_q && !rd_go;
  assign shift_ev   = (state_q == S_SHIFT) && pv_q;
  assign shift_done = (state_q == S_SHIFT) && !pv_q && !rd_go;
  assign hit        = scan_ev && (cmd_q.kind != KIND_TICK) && (rdata_q.pin == cmd_q.pin);
  assign ph0        = (phase_q == '0);
  assign off_now    = !ph0 && (rdata_q.duty <= phase_q) && !rdata_q.latch;
  assign emit_new   = scan_ev && (cmd_q.kind == KIND_TICK) && (ph0 || off_now);
  assign new_lvl    = ph0 ? ((rdata_q.duty != '0) ^ rdata_q.inv) : rdata_q.inv;
  assign full       = (count_q == CntW'(MAX_CHANNELS));

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = pidx_q;
    wdata = rdata_q;
    if (emit_new) begin
      we          = 1'b1;
      wdata.latch = !ph0;
    end
    if (hit && (cmd_q.kind == KIND_SET)) begin
      we    = 1'b1;
      wdata = '{pin: cmd_q.pin, duty: cmd_q.duty, inv: cmd_q.inv, latch: rdata_q.latch};
    end
    if (scan_done && (cmd_q.kind == KIND_SET) && !full) begin
      we    = 1'b1;
      waddr = count_q[IdxW-1:0];
      wdata = '{pin: cmd_q.pin, duty: cmd_q.duty, inv: cmd_q.inv, latch: 1'b0};
    end
    if (shift_ev) begin
      we    = 1'b1;
      waddr = pidx_q - IdxW'(1);
      wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_go) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= '0;
      count_q    <= '0;
      phase_q    <= '0;
      rd_idx_q   <= '0;
      pv_q       <= 1'b0;
      pidx_q     <= '0;
      held_v_q   <= 1'b0;
      held_pin_q <= '0;
      held_lvl_q <= 1'b0;
      stop_inv_q <= 1'b0;
      res_v_q    <= 1'b0;
      res_q      <= '0;
    end else begin
      res_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            rd_idx_q <= '0;
            pv_q     <= 1'b0;
            state_q  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_go) begin
            rd_idx_q <= rd_idx_q + CntW'(1);
          end
          pv_q   <= rd_go;
          pidx_q <= raddr;
          // one write is held back so the last one of a tick can be marked
          if (emit_new) begin
            if (held_v_q) begin
              res_v_q <= 1'b1;
              res_q   <= '{pin: held_pin_q, level: held_lvl_q, status: STAT_WRITE, last: 1'b0};
            end
            held_v_q   <= 1'b1;
            held_pin_q <= rdata_q.pin;
            held_lvl_q <= new_lvl;
          end
          if (hit) begin
            pv_q <= 1'b0;
            if (cmd_q.kind == KIND_SET) begin
              state_q <= S_IDLE;
            end else begin
              stop_inv_q <= rdata_q.inv;
              rd_idx_q   <= CntW'(pidx_q) + CntW'(1);
              state_q    <= S_SHIFT;
            end
          end
          if (scan_done) begin
            state_q <= S_IDLE;
            case (cmd_q.kind)
              KIND_TICK: begin
                if (held_v_q) begin
                  res_v_q <= 1'b1;
                  res_q   <= '{pin: held_pin_q, level: held_lvl_q, status: STAT_WRITE,
                               last: 1'b1};
                end
                held_v_q <= 1'b0;
                if (count_q != '0) begin
                  phase_q <= (phase_q == PhaseLast) ? '0 : phase_q + 8'd1;
                end
              end
              KIND_SET: begin
                if (full) begin
                  res_v_q <= 1'b1;
                  res_q   <= '{pin: cmd_q.pin, level: 1'b0, status: STAT_FULL, last: 1'b1};
                end else begin
                  count_q <= count_q + CntW'(1);
                end
              end
              KIND_STOP: begin
                res_v_q <= 1'b1;
                res_q   <= '{pin: cmd_q.pin, level: 1'b0, status: STAT_UNKNOWN, last: 1'b1};
              end
              default: begin
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (rd_go) begin
            rd_idx_q <= rd_idx_q + CntW'(1);
          end
          pv_q   <= rd_go;
          pidx_q <= raddr;
          if (shift_done) begin
            count_q <= count_q - CntW'(1);
            res_v_q <= 1'b1;
            res_q   <= '{pin: cmd_q.pin, level: stop_inv_q, status: STAT_WRITE, last: 1'b1};
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/multi_channel_soft_pwm.sv]
// top level of the multi-channel soft pwm
// Commands are taken while busy is low into a two-entry queue; busy rises only when
// that queue is full. The channel engine runs one command at a time from its table
// memory with one read port. A tick walks the table and gives one pin write per channel
// at phase zero and one per channel that turns off at a later phase; a set or stop
// searches the table, and a stop then moves each channel behind the removed one down
// by one to close the gap. Results appear on strobe_o for a single cycle and cannot be
// held off; the last write of a tick leaves once the walk is over, so that it carries
// last_o.
module multi_channel_soft_pwm import mcsp_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       kind_i,
  input  logic [PinW-1:0]  pin_id_i,
  input  logic [DutyW-1:0] duty_i,
  input  logic             invert_i,
  output logic             strobe_o,
  output logic [PinW-1:0]  pin_id_res_o,
  output logic             level_o,
  output logic [1:0]       status_o,
  output logic             last_o
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  res_t res;

  mcsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_i),
    .pin_id_i    (pin_id_i),
    .duty_i      (duty_i),
    .invert_i    (invert_i),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  mcsp_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (strobe_o),
    .res_o       (res)
  );

  assign pin_id_res_o = res.pin;
  assign level_o      = res.level;
  assign status_o     = res.status;
  assign last_o       = res.last;

  // error reports are always the only result of their command
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o != STAT_WRITE) |-> last_o)
    else $error("error result without last");

  // the engine leaves idle once it takes a command
  a_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("engine took a command and stayed idle");

endmodule

[verif/multi_channel_soft_pwm_tb.sv]
// self-checking testbench of the multi-channel soft pwm: directed table, then random commands
module multi_channel_soft_pwm_tb;
  import mcsp_pkg::*;

  localparam int unsigned NumChan     = MaxChannelsDef;
  localparam logic [1:0]  KindUnused  = 2'd3;
  localparam int          RandItems   = 240;
  localparam int          PoolSize    = 20;
  localparam int unsigned IdleLimit   = 3000;
  localparam int          DrainCycles = 100;

  typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE} check_e;

  typedef struct {
    logic [1:0]       kind;
    logic [PinW-1:0]  pin;
    logic [DutyW-1:0] duty;
    logic             inv;
    check_e           chk;
    res_t             typed;
  } pwm_cmd_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       kind_i;
  logic [PinW-1:0]  pin_id_i;
  logic [DutyW-1:0] duty_i;
  logic             invert_i;
  logic             strobe_o;
  logic [PinW-1:0]  pin_id_res_o;
  logic             level_o;
  logic [1:0]       status_o;
  logic             last_o;

  multi_channel_soft_pwm #(.MAX_CHANNELS(NumChan)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .pin_id_i     (pin_id_i),
    .duty_i       (duty_i),
    .invert_i     (invert_i),
    .strobe_o     (strobe_o),
    .pin_id_res_o (pin_id_res_o),
    .level_o      (level_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  // channel table as the block should hold it
  logic [PinW-1:0]  chan_pin_q  [NumChan];
  logic [DutyW-1:0] chan_duty_q [NumChan];
  logic             chan_inv_q  [NumChan];
  logic             chan_off_q  [NumChan];
  int               chan_cnt;
  logic [7:0]       pwm_phase;

  res_t        step_writes[$];
  res_t        pin_writes_due[$];
  int unsigned err_cnt = 0;
  int unsigned write_cnt = 0;
  int unsigned cmd_cnt = 0;
  int unsigned tick_cnt = 0;
  int unsigned full_cnt = 0;
  int unsigned unknown_cnt = 0;
  int unsigned wrap_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic res_t mk_res(logic [PinW-1:0] pin, logic lvl, status_e st, logic lst);
    res_t r;
    r.pin    = pin;
    r.level  = lvl;
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  function automatic pwm_cmd_t mk_cmd(logic [1:0] kind, logic [PinW-1:0] pin,
                                      logic [DutyW-1:0] duty, logic inv,
                                      check_e chk, res_t typed);
    pwm_cmd_t c;
    c.kind  = kind;
    c.pin   = pin;
    c.duty  = duty;
    c.inv   = inv;
    c.chk   = chk;
    c.typed = typed;
    return c;
  endfunction

  // advances the channel table by one command and collects the pin writes and error results it causes
  function automatic void pwm_step(pwm_cmd_t c);
    int   idx;
    logic old_inv;
    res_t r;
    idx = -1;
    step_writes.delete();
    for (int i = 0; i < chan_cnt; i++)
      if (idx < 0 && chan_pin_q[i] == c.pin) idx = i;
    case (c.kind)
      KIND_TICK: begin
        if (chan_cnt != 0) begin
          for (int i = 0; i < chan_cnt; i++) begin
            if (pwm_phase == 8'd0) begin
              chan_off_q[i] = 1'b0;
              step_writes.push_back(mk_res(chan_pin_q[i],
                                           (chan_duty_q[i] != 8'd0) ^ chan_inv_q[i],
                                           STAT_WRITE, 1'b0));
            end else if (chan_duty_q[i] <= pwm_phase && !chan_off_q[i]) begin
              step_writes.push_back(mk_res(chan_pin_q[i], chan_inv_q[i], STAT_WRITE, 1'b0));
              chan_off_q[i] = 1'b1;
            end
          end
          if (pwm_phase == PhaseLast) begin
            pwm_phase = 8'd0;
            wrap_cnt++;
          end else begin
            pwm_phase++;
          end
        end
      end
      KIND_SET: begin
        if (idx >= 0) begin
          chan_duty_q[idx] = c.duty;
          chan_inv_q[idx]  = c.inv;
        end else if (chan_cnt >= int'(NumChan)) begin
          step_writes.push_back(mk_res(c.pin, 1'b0, STAT_FULL, 1'b0));
        end else begin
          chan_pin_q[chan_cnt]  = c.pin;
          chan_duty_q[chan_cnt] = c.duty;
          chan_inv_q[chan_cnt]  = c.inv;
          chan_off_q[chan_cnt]  = 1'b0;
          chan_cnt++;
        end
      end
      KIND_STOP: begin
        if (idx < 0) begin
          step_writes.push_back(mk_res(c.pin, 1'b0, STAT_UNKNOWN, 1'b0));
        end else begin
          old_inv = chan_inv_q[idx];
          for (int i = idx; i + 1 < chan_cnt; i++) begin
            chan_pin_q[i]  = chan_pin_q[i + 1];
            chan_duty_q[i] = chan_duty_q[i + 1];
            chan_inv_q[i]  = chan_inv_q[i + 1];
            chan_off_q[i]  = chan_off_q[i + 1];
          end
          chan_cnt--;
          step_writes.push_back(mk_res(c.pin, old_inv, STAT_WRITE, 1'b0));
        end
      end
      default: ;
    endcase
    if (step_writes.size() > 0) begin
      r = step_writes.pop_back();
      r.last = 1'b1;
      step_writes.push_back(r);
    end
  endfunction

  function automatic int next_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_idle || sel < 65) return 0;
    if (sel < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(pwm_cmd_t c);
    int gap;
    kind_i   <= c.kind;
    pin_id_i <= c.pin;
    duty_i   <= c.duty;
    invert_i <= c.inv;
    start    <= 1'b1;
    do @(posedge clk_i); while (busy);
    // transfer taken at this edge
    pwm_step(c);
    if (c.kind != KindUnused) cmd_cnt++;
    if (c.kind == KIND_TICK) tick_cnt++;
    if (c.chk == CHK_MODEL) begin
      foreach (step_writes[i]) pin_writes_due.push_back(step_writes[i]);
    end else if (c.chk == CHK_ONE) begin
      pin_writes_due.push_back(c.typed);
    end
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && strobe_o) begin
      write_cnt++;
      if (pin_writes_due.size() == 0) begin
        $error("unexpected result: pin_id_res %0d level %0d status %0d last %0d",
               pin_id_res_o, level_o, status_o, last_o);
        err_cnt++;
      end else begin
        want = pin_writes_due.pop_front();
        if (want.status == STAT_FULL) full_cnt++;
        if (want.status == STAT_UNKNOWN) unknown_cnt++;
        if (pin_id_res_o !== want.pin) begin
          $error("pin_id_res: expected %0d, got %0d", want.pin, pin_id_res_o);
          err_cnt++;
        end
        if (level_o !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, level_o);
          err_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_cnt++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    pwm_cmd_t         dir_tbl[$];
    pwm_cmd_t         c;
    logic [PinW-1:0]  pool [PoolSize];
    int               rand_cnt;
    int               sel;
    rst_ni   <= 1'b0;
    start    <= 1'b0;
    kind_i   <= KIND_TICK;
    pin_id_i <= '0;
    duty_i   <= '0;
    invert_i <= 1'b0;
    chan_cnt  = 0;
    pwm_phase = 8'd0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    dir_tbl.push_back(mk_cmd(KIND_TICK, 7'd0, 8'd0, 1'b0, CHK_NONE, '0));
    dir_tbl.push_back(mk_cmd(KIND_STOP, 7'd5, 8'd0, 1'b0, CHK_ONE,
                             mk_res(7'd5, 1'b0, STAT_UNKNOWN, 1'b1)));
    dir_tbl.push_back(mk_cmd(KindUnused, 7'd127, 8'd255, 1'b1, CHK_NONE, '0));
    dir_tbl.push_back(mk_cmd(KIND_SET, 7'd0, 8'd0, 1'b0, CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_SET, 7'd127, 8'd255, 1'b1, CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_SET, 7'd42, 8'd1, 1'b0, CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_SET, 7'd85, 8'd128, 1'b1, CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_TICK, 7'd0, 8'd0, 1'b0, CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_SET, 7'd42, 8'd3, 1'b1, CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_TICK, 7'd127, 8'd255, 1'b1, CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_TICK, 7'd0, 8'd0, 1'b0, CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_TICK, 7'd0, 8'd0, 1'b0, CHK_MODEL, '0));
    for (int i = 0; i < 12; i++)
      dir_tbl.push_back(mk_cmd(KIND_SET, 7'(3 + 9 * i), 8'(21 * i), i[0], CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_SET, 7'd100, 8'd77, 1'b1, CHK_ONE,
                             mk_res(7'd100, 1'b0, STAT_FULL, 1'b1)));
    dir_tbl.push_back(mk_cmd(KIND_STOP, 7'd127, 8'd0, 1'b0, CHK_MODEL, '0));
    dir_tbl.push_back(mk_cmd(KIND_STOP, 7'd99, 8'd0, 1'b0, CHK_ONE,
                             mk_res(7'd99, 1'b0, STAT_UNKNOWN, 1'b1)));
    dir_tbl.push_back(mk_cmd(KIND_TICK, 7'd0, 8'd0, 1'b0, CHK_MODEL, '0));
    foreach (dir_tbl[i]) send(dir_tbl[i]);

    // random commands over a small pin pool so the table fills and drains
    foreach (pool[i]) pool[i] = 7'($urandom_range(0, 127));
    rand_cnt = 0;
    while (rand_cnt < RandItems) begin
      sel = $urandom_range(0, 99);
      c = mk_cmd(KIND_TICK, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), CHK_MODEL, '0);
      if (sel >= 70 && sel < 88) begin
        c.kind = KIND_SET;
        if ($urandom_range(0, 4) != 0) c.pin = pool[$urandom_range(0, PoolSize - 1)];
        case ($urandom_range(0, 9))
          0: c.duty = 8'd0;
          1: c.duty = 8'd255;
          2: c.duty = 8'd1;
          3: c.duty = 8'd254;
          default: ;
        endcase
      end else if (sel >= 88 && sel < 98) begin
        c.kind = KIND_STOP;
        if (chan_cnt > 0 && $urandom_range(0, 3) != 0)
          c.pin = chan_pin_q[$urandom_range(0, chan_cnt - 1)];
      end else if (sel >= 98) begin
        c.kind = KindUnused;
      end
      if (c.kind != KindUnused) begin
        rand_cnt++;
        if (rand_cnt % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      end
      send(c);
    end
    start <= 1'b0;

    while (pin_writes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d commands (%0d ticks, %0d phase wraps), %0d results checked",
             cmd_cnt, tick_cnt, wrap_cnt, write_cnt);
    $display("error results seen: %0d table full, %0d unknown stop", full_cnt, unknown_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mcsp_pkg.sv
rtl/core/mcsp_front.sv
rtl/core/mcsp_back.sv
rtl/core/multi_channel_soft_pwm.sv
verif/multi_channel_soft_pwm_tb.sv
